// ----- design/homogeneous_vertex_transform_defines.svh -----
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define HVT_ASSERT_SAME(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define HVT_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ----- design/hvt_pkg.sv -----
package hvt_pkg;

   localparam int COORD_W  = 32;
   localparam int COEF_W   = 16;
   localparam int LANE_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int ROW_W    = 4 * LANE_W;
   localparam int PROD_W   = COORD_W + COEF_W;
   localparam int ACC_W    = COORD_W + COEF_W + 2;
   localparam int NUM_W    = ACC_W + FRAC_W;
   localparam int REM_W    = ACC_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int PIPE_D   = COORD_W + 4;

   localparam logic [CSR_IDX_W-1:0] IDX_ROW0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_ROW1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_ROW2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_ROW3 = 2'd3;

   localparam logic [ROW_W-1:0] ONE_COEF   = ROW_W'(64'h1000);
   localparam logic [ROW_W-1:0] ROW0_RESET = ONE_COEF;
   localparam logic [ROW_W-1:0] ROW1_RESET = ONE_COEF << LANE_W;
   localparam logic [ROW_W-1:0] ROW2_RESET = ONE_COEF << (2 * LANE_W);
   localparam logic [ROW_W-1:0] ROW3_RESET = ONE_COEF << (3 * LANE_W);

   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [ACC_W-1:0]   den;
      logic [REM_W-1:0]   rem;
      logic [COORD_W-1:0] quo;
      logic               neg;
      logic               ovf;
      logic               zero;
   } div_stage_type;

endpackage

// ----- design/hvt_dot.sv -----
module hvt_dot
   import hvt_pkg::*;
(
   input  logic                       clock,
   input  logic signed [COORD_W-1:0]  x,
   input  logic signed [COORD_W-1:0]  y,
   input  logic signed [COORD_W-1:0]  z,
   input  logic signed [COEF_W-1:0]   c0,
   input  logic signed [COEF_W-1:0]   c1,
   input  logic signed [COEF_W-1:0]   c2,
   input  logic signed [COEF_W-1:0]   c3,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [COEF_W-1:0] c3_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, tr_ext;

   // Register the three products
   always_ff @(posedge clock) begin
      px_ff <= x * c0;
      py_ff <= y * c1;
      pz_ff <= z * c2;
      c3_ff <= c3;
   end

   // Add products and the translation term
   always_comb begin
      tr_ext = ACC_W'(c3_ff) <<< FRAC_W;
      acc_in = ACC_W'(px_ff) + ACC_W'(py_ff) + ACC_W'(pz_ff) + tr_ext;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- design/hvt_div.sv -----
module hvt_div
   import hvt_pkg::*;
(
   input  logic                      clock,
   input  logic signed [ACC_W-1:0]   num,
   input  logic signed [ACC_W-1:0]   den,
   output logic signed [COORD_W-1:0] quo,
   output logic                      fault
);

   div_stage_type stage_ff [0:COORD_W];
   div_stage_type stage_in;
   logic [ACC_W-1:0]   nmag, dmag;
   logic [NUM_W-1:0]   nfull;
   logic [COORD_W-1:0] half, qlast;
   div_stage_type      last;

   // Take magnitudes and check the quotient range
   always_comb begin
      nmag  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      dmag  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      nfull = {nmag, {FRAC_W{1'b0}}};
      stage_in.num  = nfull;
      stage_in.den  = dmag;
      stage_in.rem  = REM_W'(nfull >> COORD_W);
      stage_in.quo  = '0;
      stage_in.neg  = num[ACC_W-1] ^ den[ACC_W-1];
      stage_in.ovf  = (nfull >> COORD_W) >= NUM_W'(dmag);
      stage_in.zero = (dmag == '0);
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= stage_in;
   end

   // One quotient bit per stage
   for (genvar k = 1; k <= COORD_W; k++) begin : g_step
      localparam int BIT = COORD_W - k;
      logic [REM_W-1:0] sh;
      logic             ge;
      div_stage_type    nxt;
      always_comb begin
         nxt = stage_ff[k-1];
         sh  = {stage_ff[k-1].rem[REM_W-2:0], stage_ff[k-1].num[BIT]};
         ge  = sh >= {1'b0, stage_ff[k-1].den};
         nxt.rem = ge ? (sh - {1'b0, stage_ff[k-1].den}) : sh;
         nxt.quo = {stage_ff[k-1].quo[COORD_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         stage_ff[k] <= nxt;
      end
   end

   // Saturate and apply the sign, or give zero on a zero divisor
   always_comb begin
      last  = stage_ff[COORD_W];
      half  = {1'b1, {(COORD_W-1){1'b0}}};
      qlast = last.quo;
      if (last.zero) begin
         quo = '0;
      end else if (last.neg) begin
         quo = (last.ovf || qlast > half) ? half : COORD_W'(-qlast);
      end else begin
         quo = (last.ovf || qlast[COORD_W-1]) ? ~half : qlast;
      end
      fault = last.zero;
   end

endmodule

// ----- design/homogeneous_vertex_transform.sv -----
// Transforms one Q16.16 point (x, y, z, 1) by a 4x4 Q4.12 matrix and divides
// x, y and z by w. A point is taken in every cycle (busy stays low) and its
// result appears on rsp_valid after the dot-product, divider and output
// registers; the divider lanes set the depth and resolve one quotient bit per
// stage. Results cannot be stalled. Quotients out of range saturate; w equal
// to zero gives zero coordinates with rsp_divide_fault set. Write the matrix
// rows through csr_ only while no point is in flight.
module homogeneous_vertex_transform
   import hvt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_W-1:0]    req_in_x,
   input  logic signed [COORD_W-1:0]    req_in_y,
   input  logic signed [COORD_W-1:0]    req_in_z,
   output logic                         rsp_valid,
   output logic signed [COORD_W-1:0]    rsp_out_x,
   output logic signed [COORD_W-1:0]    rsp_out_y,
   output logic signed [COORD_W-1:0]    rsp_out_z,
   output logic                         rsp_divide_fault,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [ROW_W-1:0]             csr_data
);

`include "homogeneous_vertex_transform_defines.svh"

   logic [ROW_W-1:0] row_ff [0:3];
   logic [PIPE_D-1:0] vld_ff, vld_in;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [ACC_W-1:0]   acc [0:3];
   logic signed [COORD_W-1:0] quo [0:2];
   logic [2:0] flt;
   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic fault_ff, rsp_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Reset the matrix rows to identity and write them through csr_
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW0_RESET;
         row_ff[1] <= ROW1_RESET;
         row_ff[2] <= ROW2_RESET;
         row_ff[3] <= ROW3_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            IDX_ROW0: row_ff[0] <= csr_data;
            IDX_ROW1: row_ff[1] <= csr_data;
            IDX_ROW2: row_ff[2] <= csr_data;
            IDX_ROW3: row_ff[3] <= csr_data;
            default:  row_ff[0] <= row_ff[0];
         endcase
      end
   end

   // Capture the point
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         x_ff <= req_in_x;
         y_ff <= req_in_y;
         z_ff <= req_in_z;
      end
   end

   // Advance the transaction valid chain
   assign vld_in = {vld_ff[PIPE_D-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE_D-1];
      end
   end

   // One dot-product lane per matrix column
   for (genvar j = 0; j < 4; j++) begin : g_col
      hvt_dot u_dot (
         .clock (clock),
         .x     (x_ff),
         .y     (y_ff),
         .z     (z_ff),
         .c0    (row_ff[0][j*LANE_W +: COEF_W]),
         .c1    (row_ff[1][j*LANE_W +: COEF_W]),
         .c2    (row_ff[2][j*LANE_W +: COEF_W]),
         .c3    (row_ff[3][j*LANE_W +: COEF_W]),
         .acc   (acc[j])
      );
   end

   // One divider lane per coordinate
   for (genvar j = 0; j < 3; j++) begin : g_div
      hvt_div u_div (
         .clock (clock),
         .num   (acc[j]),
         .den   (acc[3]),
         .quo   (quo[j]),
         .fault (flt[j])
      );
   end

   // Merge lane results into the response
   always_ff @(posedge clock) begin
      if (vld_ff[PIPE_D-1]) begin
         ox_ff    <= quo[0];
         oy_ff    <= quo[1];
         oz_ff    <= quo[2];
         fault_ff <= flt[0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = ox_ff;
   assign rsp_out_y        = oy_ff;
   assign rsp_out_z        = oz_ff;
   assign rsp_divide_fault = fault_ff;

   `HVT_ASSERT_NEXT(a_rsp_from_pipe, clock, reset, !vld_ff[PIPE_D-1], !rsp_valid, "response without transaction")
   `HVT_ASSERT_SAME(a_fault_zero, clock, reset, rsp_valid && rsp_divide_fault, rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0, "fault with nonzero output")
   `HVT_ASSERT_SAME(a_lanes_agree, clock, reset, vld_ff[PIPE_D-1], flt[0] == flt[1] && flt[1] == flt[2], "lane fault mismatch")
   `HVT_ASSERT_NEXT(a_row0_write, clock, reset, csr_valid && csr_index == IDX_ROW0, row_ff[0] == $past(csr_data), "row 0 not written")

endmodule

// ----- sim/homogeneous_vertex_transform_tb.sv -----
`timescale 1ns / 1ps

module homogeneous_vertex_transform_tb;
   import hvt_pkg::*;

   localparam int DRAIN_CYCLES = 48;
   localparam int STALL_LIMIT  = 4000;

   typedef enum logic [1:0] { OP_POINT, OP_CSR, OP_DRAIN } op_kind_type;

   typedef struct {
      op_kind_type              kind;
      logic [COORD_W-1:0]       x, y, z;
      logic [CSR_IDX_W-1:0]     idx;
      logic [ROW_W-1:0]         data;
   } work_type;

   typedef struct {
      logic [COORD_W-1:0] x, y, z;
      logic               fault;
   } vertex_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic signed [COORD_W-1:0]  req_in_x = '0;
   logic signed [COORD_W-1:0]  req_in_y = '0;
   logic signed [COORD_W-1:0]  req_in_z = '0;
   logic                       rsp_valid;
   logic signed [COORD_W-1:0]  rsp_out_x, rsp_out_y, rsp_out_z;
   logic                       rsp_divide_fault;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [ROW_W-1:0]           csr_data = '0;

   work_type      work_q[$];
   vertex_type    vertex_q[$];
   logic [ROW_W-1:0] matrix[4];
   int            mismatches = 0;
   int            quiet = 0;
   int            gap_left = 0;
   int            burst_left = 8;
   int            stall_cycles = 0;
   bit            took_point, took_csr;
   logic          nxt_start, nxt_csr;

   homogeneous_vertex_transform dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Signed Q16.16 quotient with truncation and saturation
   function automatic logic [COORD_W-1:0] divide_sat(longint n, longint w);
      logic [127:0] nm, wm, q;
      bit           neg;
      neg = (n < 0) != (w < 0);
      nm = (n < 0) ? 128'(-n) : 128'(n);
      wm = (w < 0) ? 128'(-w) : 128'(w);
      q = (nm << FRAC_W) / wm;
      if (neg) begin
         if (q >= 128'h8000_0000) return 32'h8000_0000;
         return 32'(-q);
      end
      if (q > 128'h7fff_ffff) return 32'h7fff_ffff;
      return 32'(q);
   endfunction

   // Transform one point by the current matrix
   function automatic vertex_type transform(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [COORD_W-1:0] z);
      longint     acc[4];
      longint     pt[3];
      vertex_type v;
      pt[0] = longint'($signed(x));
      pt[1] = longint'($signed(y));
      pt[2] = longint'($signed(z));
      for (int j = 0; j < 4; j++) begin
         acc[j] = longint'($signed(matrix[3][LANE_W*j +: COEF_W])) <<< FRAC_W;
         for (int i = 0; i < 3; i++)
            acc[j] += pt[i] * longint'($signed(matrix[i][LANE_W*j +: COEF_W]));
      end
      if (acc[3] == 0) begin
         v = '{x: '0, y: '0, z: '0, fault: 1'b1};
      end else begin
         v.x = divide_sat(acc[0], acc[3]);
         v.y = divide_sat(acc[1], acc[3]);
         v.z = divide_sat(acc[2], acc[3]);
         v.fault = 1'b0;
      end
      return v;
   endfunction

   task automatic add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z);
      work_q.push_back('{kind: OP_POINT, x: x, y: y, z: z, idx: '0, data: '0});
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
      work_q.push_back('{kind: OP_CSR, x: '0, y: '0, z: '0, idx: idx, data: data});
   endtask

   task automatic add_drain();
      work_q.push_back('{kind: OP_DRAIN, x: '0, y: '0, z: '0, idx: '0, data: '0});
   endtask

   task automatic add_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                             logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3);
      add_csr(IDX_ROW0, r0);
      add_csr(IDX_ROW1, r1);
      add_csr(IDX_ROW2, r2);
      add_csr(IDX_ROW3, r3);
   endtask

   function automatic logic [ROW_W-1:0] rand_row();
      logic [ROW_W-1:0] r;
      logic [15:0]      picks[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h1000};
      case ($urandom_range(0, 3))
         0: r = {$urandom, $urandom};
         1: for (int k = 0; k < 4; k++)
               r[16*k +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
         2: for (int k = 0; k < 4; k++) r[16*k +: 16] = picks[$urandom_range(0, 4)];
         default: for (int k = 0; k < 4; k++)
               r[16*k +: 16] = 16'($signed($urandom_range(0, 31)) - 16);
      endcase
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         default: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                              : 32'h7fff_ffff - $urandom_range(0, 3);
      endcase
   endfunction

   // Driver: accept transactions, then set up the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         matrix = '{ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET};
      end else begin
         took_point = start && !busy;
         took_csr = csr_valid && csr_ready;
         if (took_point) begin
            vertex_q.push_back(transform(req_in_x, req_in_y, req_in_z));
            void'(work_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            end
         end
         if (took_csr) begin
            matrix[csr_index] = csr_data;
            void'(work_q.pop_front());
         end
         quiet = (vertex_q.size() == 0 && !took_point) ? quiet + 1 : 0;
         nxt_start = 1'b0;
         nxt_csr = 1'b0;
         if (work_q.size() > 0) begin
            case (work_q[0].kind)
               OP_POINT: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     nxt_start = 1'b1;
                     req_in_x <= work_q[0].x;
                     req_in_y <= work_q[0].y;
                     req_in_z <= work_q[0].z;
                  end
               end
               OP_CSR: begin
                  if (quiet >= DRAIN_CYCLES) begin
                     nxt_csr = 1'b1;
                     csr_index <= work_q[0].idx;
                     csr_data <= work_q[0].data;
                  end
               end
               default: begin
                  if (quiet >= DRAIN_CYCLES) void'(work_q.pop_front());
               end
            endcase
         end
         start <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   // Monitor: compare each result with the oldest expected vertex
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid) begin
         if (vertex_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%h y=%h z=%h fault=%b",
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_divide_fault);
         end else begin
            want = vertex_q.pop_front();
            if (want.x !== rsp_out_x || want.y !== rsp_out_y || want.z !== rsp_out_z ||
                want.fault !== rsp_divide_fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%h y=%h z=%h fault=%b, got x=%h y=%h z=%h fault=%b",
                           want.x, want.y, want.z, want.fault,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_divide_fault);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("homogeneous_vertex_transform_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // Reset-state identity: extremes of the coordinates
      add_point('0, '0, '0);
      add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'hffff_ffff, 32'h0001_0000, 32'hffff_0000);
      add_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
      // Tiny w: quotients saturate both ways
      add_drain();
      add_csr(IDX_ROW3, 64'h0001_0000_0000_0000);
      add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      add_point(32'h0100_0000, 32'hff00_0000, 32'h0000_0000);
      add_point(32'h0000_0000, 32'h0000_0010, 32'hffff_fff0);
      // Zero w column: divide fault
      add_matrix(64'h0000_0000_1000_1000, 64'h0000_1000_0000_1000,
                 64'h0000_7fff_8000_0000, 64'h0000_1234_5678_9abc);
      add_point(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff);
      add_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      // w depends on the point; of the points here, zero at the origin only
      add_matrix(64'h1000_0000_0000_1000, 64'h8000_0000_1000_0000,
                 64'h7fff_1000_0000_0000, 64'h0000_0000_0000_0000);
      add_point('0, '0, '0);
      add_point(32'h0001_0000, '0, '0);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
      // All-zero and all-ones registers
      add_matrix('0, '0, '0, '0);
      add_point(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff);
      add_matrix('1, '1, '1, '1);
      add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      add_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      add_point('0, '0, 32'hffff_0000);
      // Random phases, each with its own matrix
      for (int p = 0; p < 8; p++) begin
         add_matrix(rand_row(), rand_row(), rand_row(), rand_row());
         for (int n = 0; n < 160; n++) begin
            if (n == 80) add_drain();
            add_point(rand_coord(), rand_coord(), rand_coord());
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (work_q.size() > 0 || vertex_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && vertex_q.size() == 0) begin
         $display("homogeneous_vertex_transform_tb: done, clean");
      end else begin
         $display("homogeneous_vertex_transform_tb: done, errors");
      end
      $finish;
   end

endmodule
